### hw/rtl/trd_pkg.sv
// Shared types, constants and helper functions for the telnet receive deframer.
package trd_pkg;

  // Telnet command and control characters.
  localparam logic [7:0] ChIac  = 8'hFF;
  localparam logic [7:0] ChSb   = 8'd250;
  localparam logic [7:0] ChSe   = 8'd240;
  localparam logic [7:0] ChWill = 8'd251;
  localparam logic [7:0] ChDont = 8'd254;
  localparam logic [7:0] OptNaws = 8'd31;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChNul  = 8'h00;

  // Parser mode codes.
  localparam int ModeW = 3;
  localparam logic [ModeW-1:0] ModeData   = 3'd0;
  localparam logic [ModeW-1:0] ModeCr     = 3'd1;
  localparam logic [ModeW-1:0] ModeIac    = 3'd2;
  localparam logic [ModeW-1:0] ModeOpt    = 3'd3;
  localparam logic [ModeW-1:0] ModeSbOpt  = 3'd4;
  localparam logic [ModeW-1:0] ModeSbData = 3'd5;
  localparam logic [ModeW-1:0] ModeSbIac  = 3'd6;

  // Subnegotiation payload counter.
  localparam logic [2:0] SubCntMax = 3'd7;
  localparam logic [2:0] NawsLen   = 3'd4;

  // Result kinds.
  localparam logic KindData = 1'b0;
  localparam logic KindSize = 1'b1;

  // Queue between the parser and the result sequencer.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One queue entry: the results caused by one input item. When two is set,
  // a second data result with data1 follows the first.
  typedef struct packed {
    logic        two;
    logic        kind;
    logic [7:0]  data0;
    logic [15:0] cols;
    logic [15:0] rows;
    logic [7:0]  data1;
  } trd_entry_t;

  // Window size collection state.
  typedef struct packed {
    logic [2:0]  cnt;
    logic [15:0] cols;
    logic [15:0] rows;
  } trd_naws_t;

  // Adds one subnegotiation payload byte to the window size being collected.
  function automatic trd_naws_t trd_add_payload(trd_naws_t cur, logic [7:0] b);
    trd_naws_t res;
    res = cur;
    case (cur.cnt)
      3'd0: res.cols[15:8] = b;
      3'd1: res.cols[7:0]  = b;
      3'd2: res.rows[15:8] = b;
      3'd3: res.rows[7:0]  = b;
      default: res = cur;
    endcase
    if (cur.cnt < SubCntMax) begin
      res.cnt = cur.cnt + 3'd1;
    end
    return res;
  endfunction

endpackage

### hw/rtl/trd_front.sv
// Parser front end: accepts received bytes, tracks telnet state and builds result entries.
module trd_front import trd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       segment_end,
  input  logic       q_full,
  output logic       q_push,
  output trd_entry_t q_wdata
);

  logic [ModeW-1:0] mode;
  logic [ModeW-1:0] mode_next;
  logic [7:0]       sub_opt;
  logic [7:0]       sub_opt_next;
  trd_naws_t        naws;
  trd_naws_t        naws_next;
  logic [1:0]       emit_cnt;
  trd_entry_t       ent;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Next parser state and the results of the current byte.
  always_comb begin
    mode_next    = mode;
    sub_opt_next = sub_opt;
    naws_next    = naws;
    emit_cnt     = 2'd0;
    ent          = '0;

    case (mode)
      ModeCr: begin
        if (rx_byte == ChNul) begin
          mode_next = ModeData;
          ent.data0 = ChCr;
          emit_cnt  = 2'd1;
        end else if (rx_byte == ChLf) begin
          mode_next = ModeData;
          ent.data0 = ChLf;
          emit_cnt  = 2'd1;
        end else begin
          // A bare CR becomes LF, then the byte is parsed as plain data.
          ent.data0 = ChLf;
          emit_cnt  = 2'd1;
          if (rx_byte == ChCr) begin
            mode_next = ModeCr;
          end else if (rx_byte == ChIac) begin
            mode_next = ModeIac;
          end else begin
            mode_next = ModeData;
            ent.data1 = rx_byte;
            emit_cnt  = 2'd2;
          end
        end
      end
      ModeIac: begin
        if (rx_byte == ChIac) begin
          mode_next = ModeData;
          ent.data0 = ChIac;
          emit_cnt  = 2'd1;
        end else if (rx_byte >= ChWill && rx_byte <= ChDont) begin
          mode_next = ModeOpt;
        end else if (rx_byte == ChSb) begin
          naws_next.cnt = 3'd0;
          mode_next     = ModeSbOpt;
        end else begin
          mode_next = ModeData;
        end
      end
      ModeOpt: begin
        mode_next = ModeData;
      end
      ModeSbOpt: begin
        sub_opt_next = rx_byte;
        mode_next    = (rx_byte == ChIac) ? ModeSbIac : ModeSbData;
      end
      ModeSbData: begin
        if (rx_byte == ChIac) begin
          mode_next = ModeSbIac;
        end else begin
          naws_next = trd_add_payload(naws, rx_byte);
        end
      end
      ModeSbIac: begin
        if (rx_byte == ChSe) begin
          mode_next = ModeData;
          if (sub_opt == OptNaws && naws.cnt == NawsLen) begin
            ent.kind = KindSize;
            ent.cols = naws.cols;
            ent.rows = naws.rows;
            emit_cnt = 2'd1;
          end
        end else begin
          if (rx_byte == ChIac) begin
            naws_next = trd_add_payload(naws, rx_byte);
          end
          mode_next = ModeSbData;
        end
      end
      default: begin
        if (rx_byte == ChCr) begin
          mode_next = ModeCr;
        end else if (rx_byte == ChIac) begin
          mode_next = ModeIac;
        end else begin
          mode_next = ModeData;
          ent.data0 = rx_byte;
          emit_cnt  = 2'd1;
        end
      end
    endcase

    // Segment end flushes a pending CR as LF and drops unfinished commands.
    if (segment_end) begin
      if (mode_next == ModeCr) begin
        if (emit_cnt == 2'd0) begin
          ent.data0 = ChLf;
          emit_cnt  = 2'd1;
        end else begin
          ent.data1 = ChLf;
          emit_cnt  = 2'd2;
        end
      end
      mode_next = ModeData;
    end

    ent.two = (emit_cnt == 2'd2);
  end

  assign q_push  = accept && (emit_cnt != 2'd0);
  assign q_wdata = ent;

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= ModeData;
      sub_opt <= '0;
      naws    <= '0;
    end else if (accept) begin
      mode    <= mode_next;
      sub_opt <= sub_opt_next;
      naws    <= naws_next;
    end
  end

endmodule

### hw/rtl/trd_queue.sv
// Small register queue of result entries between the parser and the result sequencer.
module trd_queue import trd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  trd_entry_t wdata,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output trd_entry_t rdata
);

  trd_entry_t       slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == QCntW'(QDepth));
  assign not_empty = (count != '0);
  assign rdata     = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCntW'(1);
      end
    end
  end

endmodule

### hw/rtl/trd_back.sv
// Result sequencer: unpacks queue entries into single result items in an output register.
module trd_back import trd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_not_empty,
  input  trd_entry_t  q_rdata,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  user_byte,
  output logic [15:0] window_columns,
  output logic [15:0] window_rows,
  output logic        last_result
);

  logic phase;
  logic load;

  // The output register takes a new item when it is empty or being drained.
  assign load  = q_not_empty && (!out_valid || out_ready);
  assign q_pop = load && (!q_rdata.two || phase);

  // Control: output valid and which half of a two-result entry is next.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= q_rdata.two && !phase;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      if (phase) begin
        result_kind    <= KindData;
        user_byte      <= q_rdata.data1;
        window_columns <= '0;
        window_rows    <= '0;
        last_result    <= 1'b1;
      end else begin
        result_kind    <= q_rdata.kind;
        user_byte      <= q_rdata.data0;
        window_columns <= q_rdata.cols;
        window_rows    <= q_rdata.rows;
        last_result    <= !q_rdata.two;
      end
    end
  end

endmodule

### hw/rtl/telnet_receive_deframer.sv
// The first result of a byte enters the queue when the byte is accepted, then the output
// register. One byte per cycle unless the queue is full; a byte with two results holds the
// output for both; the four-entry parser-to-output queue absorbs that and output stalls.
// Reset (synchronous, active high) returns the parser to plain data mode, clears the
// window size collection state and empties the queue and the output register.
// Top level of the telnet receive deframer.
module telnet_receive_deframer import trd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        segment_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  user_byte,
  output logic [15:0] window_columns,
  output logic [15:0] window_rows,
  output logic        last_result
);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_not_empty;
  trd_entry_t q_wdata;
  trd_entry_t q_rdata;

  // Parser front end.
  trd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .segment_end (segment_end),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  // Entry queue.
  trd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  // Result sequencer.
  trd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (q_not_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .user_byte      (user_byte),
    .window_columns (window_columns),
    .window_rows    (window_rows),
    .last_result    (last_result)
  );

  // A window size update is always the only result of its byte.
  a_size_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KindSize |-> last_result && user_byte == 8'h00)
    else $error("window size update not a sole result");

  // Data results carry zero window fields.
  a_data_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KindData |-> window_columns == 16'h0000 &&
    window_rows == 16'h0000)
    else $error("data result with nonzero window fields");

  // The second result of a byte follows directly once the first is taken.
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=> out_valid && last_result &&
    result_kind == KindData)
    else $error("second result of a byte did not follow");

  // A byte with results always reaches a non-full queue.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue push while full");

endmodule

### bench/tb_telnet_receive_deframer.sv
// Self-checking testbench for the telnet receive deframer: directed and random byte streams.
module tb_telnet_receive_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import trd_pkg::*;

  // Telnet NOP, used as an "other" two-byte command.
  localparam logic [7:0] ChNop = 8'd241;
  localparam int IdlePct = 38;
  localparam int HoldCycles = 90;
  localparam int QuietLimit = 3000;
  localparam int RandomItems = 550;

  // One result of the block as the checker sees it.
  typedef struct packed {
    logic        kind;
    logic [7:0]  ubyte;
    logic [15:0] cols;
    logic [15:0] rows;
    logic        last;
  } deframer_result_t;

  // One byte of stimulus with its segment flag.
  typedef struct packed {
    logic [7:0] b;
    logic       seg;
  } rx_item_t;

  // Tracks the parser state, predicts the results of each accepted byte and
  // checks the results that the block delivers against them.
  class deframer_scoreboard;
    logic [ModeW-1:0] mode;
    logic [7:0]       sub_option;
    logic [2:0]       payload_count;
    logic [15:0]      cols_acc;
    logic [15:0]      rows_acc;
    deframer_result_t step_out[$];
    deframer_result_t awaited[$];
    int               fail_count;

    function new();
      mode = ModeData;
      sub_option = '0;
      payload_count = '0;
      cols_acc = '0;
      rows_acc = '0;
      fail_count = 0;
    endfunction

    function void push_data(logic [7:0] b);
      deframer_result_t r;
      r = '0;
      r.kind = KindData;
      r.ubyte = b;
      step_out.push_back(r);
    endfunction

    function void push_size();
      deframer_result_t r;
      r = '0;
      r.kind = KindSize;
      r.cols = cols_acc;
      r.rows = rows_acc;
      step_out.push_back(r);
    endfunction

    // A byte seen in plain data mode.
    function void plain_byte(logic [7:0] b);
      if (b == ChCr) begin
        mode = ModeCr;
      end else if (b == ChIac) begin
        mode = ModeIac;
      end else begin
        mode = ModeData;
        push_data(b);
      end
    endfunction

    // Window size bytes arrive big-endian: columns first, then rows.
    function void take_payload(logic [7:0] b);
      case (payload_count)
        3'd0: cols_acc[15:8] = b;
        3'd1: cols_acc[7:0] = b;
        3'd2: rows_acc[15:8] = b;
        3'd3: rows_acc[7:0] = b;
        default: ;
      endcase
      if (payload_count < SubCntMax) payload_count++;
    endfunction

    function void note_byte(logic [7:0] b, logic seg_end);
      step_out.delete();
      case (mode)
        ModeCr: begin
          if (b == ChNul) begin
            mode = ModeData;
            push_data(ChCr);
          end else if (b == ChLf) begin
            mode = ModeData;
            push_data(ChLf);
          end else begin
            push_data(ChLf);
            plain_byte(b);
          end
        end
        ModeIac: begin
          if (b == ChIac) begin
            mode = ModeData;
            push_data(ChIac);
          end else if (b >= ChWill && b <= ChDont) begin
            mode = ModeOpt;
          end else if (b == ChSb) begin
            payload_count = '0;
            mode = ModeSbOpt;
          end else begin
            mode = ModeData;
          end
        end
        ModeOpt: mode = ModeData;
        ModeSbOpt: begin
          sub_option = b;
          mode = (b == ChIac) ? ModeSbIac : ModeSbData;
        end
        ModeSbData: begin
          if (b == ChIac) mode = ModeSbIac;
          else take_payload(b);
        end
        ModeSbIac: begin
          if (b == ChSe) begin
            mode = ModeData;
            if (sub_option == OptNaws && payload_count == NawsLen) push_size();
          end else begin
            if (b == ChIac) take_payload(b);
            mode = ModeSbData;
          end
        end
        default: plain_byte(b);
      endcase

      // A segment end flushes a pending CR and drops any unfinished command.
      if (seg_end) begin
        if (mode == ModeCr) push_data(ChLf);
        mode = ModeData;
      end

      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) awaited.push_back(step_out[i]);
    endfunction

    task report(string what);
      fail_count++;
      if (fail_count <= 40) $display("%0t: mismatch: %s", $time, what);
    endtask

    task check_result(logic kind, logic [7:0] ubyte, logic [15:0] cols, logic [15:0] rows,
                      logic last);
      deframer_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result, kind %0d byte %02h", kind, ubyte));
        return;
      end
      want = awaited.pop_front();
      if (kind !== want.kind)
        report($sformatf("result_kind %0d, expected %0d", kind, want.kind));
      if (ubyte !== want.ubyte)
        report($sformatf("user_byte %02h, expected %02h", ubyte, want.ubyte));
      if (cols !== want.cols)
        report($sformatf("window_columns %0d, expected %0d", cols, want.cols));
      if (rows !== want.rows)
        report($sformatf("window_rows %0d, expected %0d", rows, want.rows));
      if (last !== want.last)
        report($sformatf("last_result %0d, expected %0d", last, want.last));
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        segment_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [7:0]  user_byte;
  logic [15:0] window_columns;
  logic [15:0] window_rows;
  logic        last_result;

  deframer_scoreboard sb = new();
  rx_item_t           byte_stream[$];
  int                 tx_idle_pct = IdlePct;
  int                 rx_idle_pct = IdlePct;
  bit                 hold_rx = 1'b0;
  int                 quiet_cycles = 0;

  telnet_receive_deframer i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .segment_end   (segment_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .user_byte     (user_byte),
    .window_columns(window_columns),
    .window_rows   (window_rows),
    .last_result   (last_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Handshake monitor, checker and watchdog on quiet cycles.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(rx_byte, segment_end);
      if (out_valid && out_ready)
        sb.check_result(result_kind, user_byte, window_columns, window_rows, last_result);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk);
      end
    end
  end

  function automatic void put(logic [7:0] b, logic seg);
    rx_item_t it;
    it.b = b;
    it.seg = seg;
    byte_stream.push_back(it);
  endfunction

  function automatic logic rand_seg();
    return ($urandom_range(24) == 0);
  endfunction

  // Payload bytes lean toward the extremes of the window size fields.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(5);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Window size subnegotiation, mostly well formed, sometimes bent.
  function automatic void put_naws();
    int unsigned r;
    int          len;
    logic [7:0]  opt;
    logic [7:0]  b;
    logic [7:0]  junk;
    r = $urandom_range(9);
    opt = (r < 8) ? OptNaws : ((r == 8) ? 8'($urandom_range(255)) : ChIac);
    len = ($urandom_range(9) < 8) ? 4 : $urandom_range(9);
    put(ChIac, rand_seg());
    put(ChSb, rand_seg());
    put(opt, rand_seg());
    for (int i = 0; i < len; i++) begin
      // An ignored IAC pair in the middle of the payload.
      if ($urandom_range(9) == 0) begin
        junk = 8'($urandom_range(254));
        if (junk == ChSe) junk = ChNop;
        put(ChIac, rand_seg());
        put(junk, rand_seg());
      end
      b = pick_byte();
      put(b, rand_seg());
      if (b == ChIac) put(ChIac, rand_seg());
    end
    if ($urandom_range(9) < 9) begin
      put(ChIac, rand_seg());
      put(ChSe, rand_seg());
    end else begin
      put(pick_byte(), rand_seg());
    end
  endfunction

  function automatic void build_random(int target);
    int unsigned r;
    int unsigned c;
    logic [7:0]  cmd;
    while (byte_stream.size() < target) begin
      r = $urandom_range(99);
      if (r < 25) begin
        put_naws();
      end else if (r < 50) begin
        repeat ($urandom_range(1, 6)) put(8'($urandom_range(255)), rand_seg());
      end else if (r < 65) begin
        // CR followed by each kind of successor.
        c = $urandom_range(4);
        put(ChCr, rand_seg());
        case (c)
          0: put(ChNul, rand_seg());
          1: put(ChLf, rand_seg());
          2: put(ChCr, rand_seg());
          3: put(ChIac, rand_seg());
          default: put(8'($urandom_range(255)), rand_seg());
        endcase
      end else if (r < 73) begin
        put(ChIac, rand_seg());
        put(ChIac, rand_seg());
      end else if (r < 83) begin
        put(ChIac, rand_seg());
        put(8'($urandom_range(ChWill, ChDont)), rand_seg());
        put(pick_byte(), rand_seg());
      end else if (r < 90) begin
        cmd = 8'($urandom_range(ChSb - 1));
        put(ChIac, rand_seg());
        put(cmd, rand_seg());
      end else begin
        put(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endfunction

  // Offers one byte after a random gap and waits until it is accepted.
  task automatic drive_byte(rx_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= it.b;
    segment_end <= it.seg;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed bytes: CR handling, escapes, commands and a window size update.
    put(8'h41, 1'b0);
    put(ChCr, 1'b0);
    put(ChNul, 1'b0);
    put(ChCr, 1'b0);
    put(ChLf, 1'b0);
    put(ChCr, 1'b0);
    put(ChCr, 1'b0);
    put(8'h7A, 1'b0);
    put(ChCr, 1'b1);
    put(ChCr, 1'b0);
    put(ChIac, 1'b0);
    put(ChIac, 1'b0);
    put(ChIac, 1'b0);
    put(ChWill, 1'b0);
    put(OptNaws, 1'b0);
    put(ChIac, 1'b0);
    put(ChNop, 1'b0);
    put(ChIac, 1'b0);
    put(ChSb, 1'b0);
    put(OptNaws, 1'b0);
    put(ChIac, 1'b0);
    put(ChIac, 1'b0);
    put(ChNul, 1'b0);
    put(ChNul, 1'b0);
    put(8'h18, 1'b0);
    put(ChIac, 1'b0);
    put(ChSe, 1'b1);
    foreach (byte_stream[i]) drive_byte(byte_stream[i]);

    byte_stream.delete();
    build_random(RandomItems);
    foreach (byte_stream[i]) begin
      // Long receiver hold-off with a busy sender, then a stretch with no idling.
      if (i == 120) begin
        tx_idle_pct = 0;
        hold_rx = 1'b1;
      end
      if (i == 250) rx_idle_pct = 0;
      if (i == 400) begin
        tx_idle_pct = IdlePct;
        rx_idle_pct = IdlePct;
      end
      drive_byte(byte_stream[i]);
    end
    in_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
